// ----- rtl/core/blsp_pkg.sv -----
`timescale 1ns / 1ps

package blsp_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int E2_W       = ERR_W + 1;
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int QUEUE_AW   = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    op_t                      op;
    coord_t                   cur_x;
    coord_t                   cur_y;
    coord_t                   tgt_x;
    coord_t                   tgt_y;
    logic [DELTA_W-1:0]       delta_x;
    logic signed [DELTA_W-1:0] neg_delta_y;
    logic                     step_x_neg;
    logic                     step_y_neg;
    logic signed [ERR_W-1:0]  err;
    logic                     active;
  } cmd_t;

endpackage

// ----- rtl/core/blsp_front.sv -----
`timescale 1ns / 1ps

module blsp_front
  import blsp_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_wr,
  output cmd_t                 q_cmd
);

  coord_t sx, sy, ex, ey;
  logic signed [DELTA_W-1:0] dxs, dys;
  logic [DELTA_W-1:0] adx, ady;

  assign sx = in_tdata[COORD_BITS-1:0];
  assign sy = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign ex = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign ey = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign dxs = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
  assign dys = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
  assign adx = dxs[DELTA_W-1] ? DELTA_W'(-dxs) : DELTA_W'(dxs);
  assign ady = dys[DELTA_W-1] ? DELTA_W'(-dys) : DELTA_W'(dys);

  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full;

  always_comb begin
    q_cmd             = '0;
    q_cmd.op          = op_t'(in_tuser);
    q_cmd.cur_x       = sx;
    q_cmd.cur_y       = sy;
    q_cmd.tgt_x       = ex;
    q_cmd.tgt_y       = ey;
    q_cmd.delta_x     = adx;
    q_cmd.neg_delta_y = DELTA_W'(-$signed(ady));
    q_cmd.step_x_neg  = !(sx < ex);
    q_cmd.step_y_neg  = !(sy < ey);
    q_cmd.err         = ERR_W'({2'b00, adx}) - ERR_W'({2'b00, ady});
    q_cmd.active      = !((sx == ex) && (sy == ey));
  end

endmodule

// ----- rtl/core/blsp_queue.sv -----
`timescale 1ns / 1ps

module blsp_queue
  import blsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full   = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ----- rtl/core/blsp_back.sv -----
`timescale 1ns / 1ps

module blsp_back
  import blsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_rd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, tgt_x_r, tgt_y_r;
  logic [DELTA_W-1:0]        delta_x_r;
  logic signed [DELTA_W-1:0] neg_delta_y_r;
  logic                      step_x_neg_r, step_y_neg_r;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic                      active_r, active_nxt;

  logic                      out_valid_r, out_valid_nxt;
  coord_t                    pix_x_r, pix_y_r;
  logic                      last_r;

  logic signed [E2_W-1:0]    e2, ndy_ext, dx_ext;
  logic                      step_x, step_y, last;
  logic signed [ERR_W-1:0]   add_x, add_y;
  logic                      emit;

  assign q_rd = !q_empty && (!out_valid_r || out_tready);
  assign emit = q_rd && (q_cmd.op == OP_ADVANCE) && active_r;

  assign e2      = {err_r, 1'b0};
  assign ndy_ext = E2_W'(neg_delta_y_r);
  assign dx_ext  = E2_W'({1'b0, delta_x_r});
  assign step_x  = (e2 >= ndy_ext);
  assign step_y  = (e2 <= dx_ext);
  assign add_x   = step_x ? ERR_W'(neg_delta_y_r) : '0;
  assign add_y   = step_y ? ERR_W'({1'b0, delta_x_r}) : '0;

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (step_x) begin
      cur_x_nxt = step_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (step_y) begin
      cur_y_nxt = step_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
    err_nxt    = err_r + add_x + add_y;
    last       = (cur_x_nxt == tgt_x_r) && (cur_y_nxt == tgt_y_r);
    active_nxt = active_r && !last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_rd) begin
        unique case (q_cmd.op)
          OP_START:   active_r <= q_cmd.active;
          OP_ADVANCE: active_r <= active_nxt;
          default:    active_r <= active_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && (q_cmd.op == OP_START)) begin
      cur_x_r       <= q_cmd.cur_x;
      cur_y_r       <= q_cmd.cur_y;
      tgt_x_r       <= q_cmd.tgt_x;
      tgt_y_r       <= q_cmd.tgt_y;
      delta_x_r     <= q_cmd.delta_x;
      neg_delta_y_r <= q_cmd.neg_delta_y;
      step_x_neg_r  <= q_cmd.step_x_neg;
      step_y_neg_r  <= q_cmd.step_y_neg;
      err_r         <= q_cmd.err;
    end else if (emit) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
    if (emit) begin
      pix_x_r <= cur_x_r;
      pix_y_r <= cur_y_r;
      last_r  <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = OUT_DATA_W'({pix_y_r, pix_x_r});

endmodule

// ----- rtl/core/bresenham_line_stepper.sv -----
`timescale 1ns / 1ps

// Bresenham line stepper for all octants. A transfer with in_tuser low loads
// the start and end points of a new line and produces no output; a transfer
// with in_tuser high produces the next pixel of the active line, with out_tlast
// set on the final one (the end point itself is never produced). Advances with
// no active line, and lines whose endpoints are equal, produce nothing. Input
// transfers pass through a four-entry command queue to the stepping unit,
// which retires one command per clock whenever the output register is free or
// being drained, so a sustained rate of one pixel per clock is reached.
module bresenham_line_stepper
  import blsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_x, pixel_y
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic q_wr, q_full, q_rd, q_empty;
  cmd_t wr_cmd, rd_cmd;

  blsp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_cmd     (wr_cmd)
  );

  blsp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .rd     (q_rd),
    .empty  (q_empty),
    .rd_cmd (rd_cmd)
  );

  blsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (rd_cmd),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
